>>> src/ubxp_pkg.sv
// Package for the navigation-solution frame parser.
// Holds the parse phases, protocol constants and the solution field layout table.
// No dependencies.
package ubxp_pkg;

  localparam logic [7:0] SYNC_A = 8'hB5;
  localparam logic [7:0] SYNC_B = 8'h62;

  localparam int unsigned SOLUTION_LEN = 92;
  localparam int unsigned FIELD_COUNT  = 32;
  localparam int unsigned STORE_AW     = $clog2(SOLUTION_LEN);
  localparam int unsigned FIELD_IDX_W  = $clog2(FIELD_COUNT);

  localparam logic [7:0] RESET_MATCH_CLASS = 8'h01;
  localparam logic [7:0] RESET_MATCH_ID    = 8'h07;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_CLASS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_ID    = 1'b1;

  typedef enum logic [3:0] {
    PH_SYNC_A,
    PH_SYNC_B,
    PH_CLASS,
    PH_IDENT,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CK_A,
    PH_CK_B,
    PH_FETCH,
    PH_MERGE,
    PH_SEND
  } phase_t;

  typedef struct packed {
    logic [STORE_AW-1:0] offset;
    logic [2:0]          nbytes;
    logic                sgn;
  } fld_desc_t;

  // Byte offset, size and signedness of each solution field. The reserved
  // bytes 80 to 83 belong to no field.
  function automatic fld_desc_t fld_desc(input logic [FIELD_IDX_W-1:0] idx);
    fld_desc_t d;
    case (idx)
      5'd0:    d = '{7'd0,  3'd4, 1'b0};
      5'd1:    d = '{7'd4,  3'd2, 1'b0};
      5'd2:    d = '{7'd6,  3'd1, 1'b0};
      5'd3:    d = '{7'd7,  3'd1, 1'b0};
      5'd4:    d = '{7'd8,  3'd1, 1'b0};
      5'd5:    d = '{7'd9,  3'd1, 1'b0};
      5'd6:    d = '{7'd10, 3'd1, 1'b0};
      5'd7:    d = '{7'd11, 3'd1, 1'b0};
      5'd8:    d = '{7'd12, 3'd4, 1'b0};
      5'd9:    d = '{7'd16, 3'd4, 1'b1};
      5'd10:   d = '{7'd20, 3'd1, 1'b0};
      5'd11:   d = '{7'd21, 3'd1, 1'b0};
      5'd12:   d = '{7'd22, 3'd1, 1'b0};
      5'd13:   d = '{7'd23, 3'd1, 1'b0};
      5'd14:   d = '{7'd24, 3'd4, 1'b1};
      5'd15:   d = '{7'd28, 3'd4, 1'b1};
      5'd16:   d = '{7'd32, 3'd4, 1'b1};
      5'd17:   d = '{7'd36, 3'd4, 1'b1};
      5'd18:   d = '{7'd40, 3'd4, 1'b0};
      5'd19:   d = '{7'd44, 3'd4, 1'b0};
      5'd20:   d = '{7'd48, 3'd4, 1'b1};
      5'd21:   d = '{7'd52, 3'd4, 1'b1};
      5'd22:   d = '{7'd56, 3'd4, 1'b1};
      5'd23:   d = '{7'd60, 3'd4, 1'b1};
      5'd24:   d = '{7'd64, 3'd4, 1'b1};
      5'd25:   d = '{7'd68, 3'd4, 1'b0};
      5'd26:   d = '{7'd72, 3'd4, 1'b0};
      5'd27:   d = '{7'd76, 3'd2, 1'b0};
      5'd28:   d = '{7'd78, 3'd2, 1'b0};
      5'd29:   d = '{7'd84, 3'd4, 1'b1};
      5'd30:   d = '{7'd88, 3'd2, 1'b1};
      5'd31:   d = '{7'd90, 3'd2, 1'b0};
      default: d = '{7'd0,  3'd4, 1'b0};
    endcase
    return d;
  endfunction

endpackage

>>> src/ubx_nav_pvt_frame_parser.sv
// Top level of the navigation-solution frame parser: sync hunt, header, checksum,
// payload store and the field sequencer that reads the store back one byte at a time.
// Depends on ubxp_pkg.
//
//   Channel   Direction  Handshake              Payload
//   in_       request    in_valid / in_ready    in_rx_byte
//   out_      result     out_valid / out_ready  out_field_index, out_field_value,
//                                               out_last_field
//   cfg_      write      cfg_we                 cfg_index, cfg_wdata
//
// Bytes are taken whenever in_ready is high. After the second checksum byte of a matching
// frame the block reads its 88 field bytes through the single store read port, each
// in a fetch state (address) and then a merge state, and hands out each field in a send
// state; the next byte request is taken only after the last field is accepted.
// in_ready is low while fields are being produced; a stalled out_ready holds the
// current field. Reset is synchronous and needs no clearing pass.
module ubx_nav_pvt_frame_parser #(
  parameter int unsigned MAX_PAYLOAD_LEN = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ubxp_pkg::FIELD_IDX_W-1:0] out_field_index,
  output logic [31:0]                     out_field_value,
  output logic                            out_last_field,
  input  logic                            cfg_we,
  input  logic [ubxp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_wdata
);
  import ubxp_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD_LEN + 1);

  phase_t                 phase_r, phase_nxt;
  logic [7:0]             match_class_r, match_id_r;
  logic [7:0]             frame_class_r, frame_class_nxt;
  logic [7:0]             frame_ident_r, frame_ident_nxt;
  logic [15:0]            frame_len_r, frame_len_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [7:0]             sum_a_r, sum_a_nxt;
  logic [7:0]             sum_b_r, sum_b_nxt;
  logic [FIELD_IDX_W-1:0] field_r, field_nxt;
  logic [1:0]             k_r, k_nxt;
  logic [31:0]            acc_r, acc_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [31:0]            out_value_r, out_value_nxt;

  logic [7:0]             store [SOLUTION_LEN];
  logic [7:0]             mem_q_r;
  logic [STORE_AW-1:0]    rd_addr;
  logic                   wr_en;

  logic                   byte_acc;
  logic [7:0]             b;
  logic [7:0]             add_a, add_b;
  logic [15:0]            len_full;
  logic [CNT_W-1:0]       cnt_inc;
  logic                   frame_ok;
  fld_desc_t              desc;
  logic                   last_byte;
  logic [31:0]            merged, formatted;

  assign byte_acc = in_valid && in_ready;
  assign b        = in_rx_byte;

  // Fletcher running sums, shared by every header and payload byte.
  assign add_a    = sum_a_r + b;
  assign add_b    = sum_b_r + add_a;
  assign len_full = {b, frame_len_r[7:0]};
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign frame_ok = (b == sum_b_r) && (frame_class_r == match_class_r) &&
                    (frame_ident_r == match_id_r) &&
                    (frame_len_r >= 16'(SOLUTION_LEN));

  assign desc      = fld_desc(field_r);
  assign rd_addr   = desc.offset + STORE_AW'(k_r);
  assign last_byte = (k_r == 2'(desc.nbytes - 3'd1));
  assign merged    = acc_r | (32'(mem_q_r) << {k_r, 3'b000});

  always_comb begin
    formatted = merged;
    if (desc.sgn && desc.nbytes == 3'd1 && merged[7]) begin
      formatted = merged | 32'hFFFF_FF00;
    end else if (desc.sgn && desc.nbytes == 3'd2 && merged[15]) begin
      formatted = merged | 32'hFFFF_0000;
    end
  end

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_SYNC_A: if (byte_acc) begin
        phase_nxt = (b == SYNC_A) ? PH_SYNC_B : PH_SYNC_A;
      end
      PH_SYNC_B: if (byte_acc) begin
        phase_nxt = (b == SYNC_B) ? PH_CLASS : PH_SYNC_A;
      end
      PH_CLASS:  if (byte_acc) phase_nxt = PH_IDENT;
      PH_IDENT:  if (byte_acc) phase_nxt = PH_LEN_LO;
      PH_LEN_LO: if (byte_acc) phase_nxt = PH_LEN_HI;
      PH_LEN_HI: if (byte_acc) begin
        if (len_full > 16'(MAX_PAYLOAD_LEN)) begin
          phase_nxt = PH_SYNC_A;
        end else begin
          phase_nxt = (len_full == 16'd0) ? PH_CK_A : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: if (byte_acc && 16'(cnt_inc) == frame_len_r) begin
        phase_nxt = PH_CK_A;
      end
      PH_CK_A: if (byte_acc) begin
        phase_nxt = (b == sum_a_r) ? PH_CK_B : PH_SYNC_A;
      end
      PH_CK_B: if (byte_acc) begin
        phase_nxt = frame_ok ? PH_FETCH : PH_SYNC_A;
      end
      PH_FETCH: phase_nxt = PH_MERGE;
      PH_MERGE: phase_nxt = last_byte ? PH_SEND : PH_FETCH;
      PH_SEND: if (out_ready) begin
        phase_nxt = (field_r == FIELD_IDX_W'(FIELD_COUNT - 1)) ? PH_SYNC_A : PH_FETCH;
      end
      default: phase_nxt = PH_SYNC_A;
    endcase
  end

  // Datapath and handshake outputs.
  always_comb begin
    in_ready        = !(phase_r inside {PH_FETCH, PH_MERGE, PH_SEND});
    frame_class_nxt = frame_class_r;
    frame_ident_nxt = frame_ident_r;
    frame_len_nxt   = frame_len_r;
    cnt_nxt         = cnt_r;
    sum_a_nxt       = sum_a_r;
    sum_b_nxt       = sum_b_r;
    field_nxt       = field_r;
    k_nxt           = k_r;
    acc_nxt         = acc_r;
    out_valid_nxt   = out_valid_r;
    out_value_nxt   = out_value_r;
    wr_en           = 1'b0;
    case (phase_r)
      PH_CLASS: if (byte_acc) begin
        frame_class_nxt = b;
        sum_a_nxt       = b;
        sum_b_nxt       = b;
      end
      PH_IDENT: if (byte_acc) begin
        frame_ident_nxt = b;
        sum_a_nxt       = add_a;
        sum_b_nxt       = add_b;
      end
      PH_LEN_LO: if (byte_acc) begin
        frame_len_nxt = {8'h00, b};
        sum_a_nxt     = add_a;
        sum_b_nxt     = add_b;
      end
      PH_LEN_HI: if (byte_acc) begin
        frame_len_nxt = len_full;
        sum_a_nxt     = add_a;
        sum_b_nxt     = add_b;
        cnt_nxt       = '0;
      end
      PH_PAYLOAD: if (byte_acc) begin
        wr_en     = (cnt_r < CNT_W'(SOLUTION_LEN));
        cnt_nxt   = cnt_inc;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
      end
      PH_CK_B: if (byte_acc) begin
        field_nxt = '0;
        k_nxt     = '0;
        acc_nxt   = '0;
      end
      PH_MERGE: begin
        acc_nxt = merged;
        k_nxt   = k_r + 2'd1;
        if (last_byte) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = formatted;
        end
      end
      PH_SEND: if (out_ready) begin
        out_valid_nxt = 1'b0;
        field_nxt     = field_r + FIELD_IDX_W'(1);
        k_nxt         = '0;
        acc_nxt       = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_SYNC_A;
      match_class_r <= RESET_MATCH_CLASS;
      match_id_r    <= RESET_MATCH_ID;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MATCH_CLASS: match_class_r <= cfg_wdata;
          REG_MATCH_ID:    match_id_r    <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    frame_class_r <= frame_class_nxt;
    frame_ident_r <= frame_ident_nxt;
    frame_len_r   <= frame_len_nxt;
    cnt_r         <= cnt_nxt;
    sum_a_r       <= sum_a_nxt;
    sum_b_r       <= sum_b_nxt;
    field_r       <= field_nxt;
    k_r           <= k_nxt;
    acc_r         <= acc_nxt;
    out_value_r   <= out_value_nxt;
  end

  // Payload store: one write port for received bytes, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[cnt_r[STORE_AW-1:0]] <= b;
    end
    mem_q_r <= store[rd_addr];
  end

  assign out_valid       = out_valid_r;
  assign out_field_index = field_r;
  assign out_field_value = out_value_r;
  assign out_last_field  = (field_r == FIELD_IDX_W'(FIELD_COUNT - 1));

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("byte requests taken while a field is pending");

  a_last_releases: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_field) |=> in_ready)
    else $error("parser did not resume after the last field");

  a_burst_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_field) |=> (!in_ready && !out_valid))
    else $error("field burst ended early");

endmodule
